// ===== design/utf8_text_sanitizer_core_assert.svh =====
// ---------------------------------------------------------------------------
// utf8_text_sanitizer_core assertion macros
// concurrent checks that compile away in synthesis
// ---------------------------------------------------------------------------
`ifndef UTF8_TEXT_SANITIZER_CORE_ASSERT_SVH
`define UTF8_TEXT_SANITIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define U8S_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define U8S_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define U8S_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define U8S_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/u8s_pkg.sv =====
// ---------------------------------------------------------------------------
// u8s_pkg
// shared types and constants of the utf-8 text sanitizer
// ---------------------------------------------------------------------------
package u8s_pkg;

    localparam logic [7:0]  C_DOLLAR    = 8'h24;
    localparam logic [20:0] C_VS1_LO    = 21'h00FE00;
    localparam logic [20:0] C_VS1_HI    = 21'h00FE0F;
    localparam logic [20:0] C_VS2_LO    = 21'h0E0100;
    localparam logic [20:0] C_VS2_HI    = 21'h0E01EF;
    localparam logic [20:0] C_WAVE_DASH = 21'h00301C;
    localparam logic [20:0] C_CP_DOLLAR = 21'h000024;
    localparam logic [7:0]  C_TILDE_B0  = 8'hEF;
    localparam logic [7:0]  C_TILDE_B1  = 8'hBD;
    localparam logic [7:0]  C_TILDE_B2  = 8'h9E;

    // one unit of work for the back end: 1..4 bytes, bytes[0] goes first
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/u8s_front.sv =====
// ---------------------------------------------------------------------------
// u8s_front
// sequence assembly and classification, one byte per cycle into jobs while bytes are accepted
// ---------------------------------------------------------------------------
module u8s_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_text,
    output logic           o_push,
    output u8s_pkg::t_job  o_job,
    output logic           o_idle
);

    logic [7:0]  r_held0, r_held1, r_held2;
    logic [7:0]  n_held0, n_held1, n_held2;
    logic [1:0]  r_bytes_held, n_bytes_held;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [20:0] r_accum, n_accum;

    logic [2:0]    w_len;
    logic [20:0]   w_init;
    logic [20:0]   w_cp;
    logic          w_complete;
    u8s_pkg::t_job w_raw;
    u8s_pkg::t_job w_job;

    // held bytes followed by the current byte
    always_comb begin
        w_raw.bytes = '0;
        unique case (r_bytes_held)
            2'd0: begin
                w_raw.count = 3'd1;
                w_raw.bytes[0] = i_data_byte;
            end
            2'd1: begin
                w_raw.count = 3'd2;
                w_raw.bytes[0] = r_held0;
                w_raw.bytes[1] = i_data_byte;
            end
            2'd2: begin
                w_raw.count = 3'd3;
                w_raw.bytes[0] = r_held0;
                w_raw.bytes[1] = r_held1;
                w_raw.bytes[2] = i_data_byte;
            end
            default: begin
                w_raw.count = 3'd4;
                w_raw.bytes[0] = r_held0;
                w_raw.bytes[1] = r_held1;
                w_raw.bytes[2] = r_held2;
                w_raw.bytes[3] = i_data_byte;
            end
        endcase
    end

    // lead byte decode
    always_comb begin
        priority if ((i_data_byte & 8'hF8) == 8'hF0) begin
            w_len  = 3'd4;
            w_init = {18'd0, i_data_byte[2:0]};
        end else if ((i_data_byte & 8'hF0) == 8'hE0) begin
            w_len  = 3'd3;
            w_init = {17'd0, i_data_byte[3:0]};
        end else if ((i_data_byte & 8'hE0) == 8'hC0) begin
            w_len  = 3'd2;
            w_init = {16'd0, i_data_byte[4:0]};
        end else if (!i_data_byte[7]) begin
            w_len  = 3'd1;
            w_init = {13'd0, i_data_byte};
        end else begin
            w_len  = 3'd0;
            w_init = '0;
        end
    end

    assign w_cp       = {r_accum[14:0], i_data_byte[5:0]};
    assign w_complete = ({1'b0, r_bytes_held} + 3'd1) >= r_seq_len;

    always_comb begin
        w_job        = '0;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_held2      = r_held2;
        n_bytes_held = r_bytes_held;
        n_seq_len    = r_seq_len;
        n_accum      = r_accum;
        if (r_seq_len == 3'd0) begin
            if (w_len == 3'd1) begin
                n_bytes_held = 2'd0;
                if (i_data_byte == u8s_pkg::C_DOLLAR) begin
                    w_job.count    = 3'd2;
                    w_job.bytes[0] = u8s_pkg::C_DOLLAR;
                    w_job.bytes[1] = u8s_pkg::C_DOLLAR;
                end else begin
                    w_job.count    = 3'd1;
                    w_job.bytes[0] = i_data_byte;
                end
            end else if (w_len == 3'd0 || i_end_of_text) begin
                n_bytes_held   = 2'd0;
                w_job.count    = 3'd1;
                w_job.bytes[0] = i_data_byte;
            end else begin
                n_held0      = i_data_byte;
                n_bytes_held = 2'd1;
                n_seq_len    = w_len;
                n_accum      = w_init;
            end
        end else begin
            if (w_complete) begin
                // selectors give an empty job
                if ((w_cp >= u8s_pkg::C_VS1_LO && w_cp <= u8s_pkg::C_VS1_HI) ||
                    (w_cp >= u8s_pkg::C_VS2_LO && w_cp <= u8s_pkg::C_VS2_HI)) begin
                    w_job = '0;
                end else if (w_cp == u8s_pkg::C_WAVE_DASH) begin
                    w_job.count    = 3'd3;
                    w_job.bytes[0] = u8s_pkg::C_TILDE_B0;
                    w_job.bytes[1] = u8s_pkg::C_TILDE_B1;
                    w_job.bytes[2] = u8s_pkg::C_TILDE_B2;
                end else if (w_cp == u8s_pkg::C_CP_DOLLAR) begin
                    w_job.count    = 3'd2;
                    w_job.bytes[0] = u8s_pkg::C_DOLLAR;
                    w_job.bytes[1] = u8s_pkg::C_DOLLAR;
                end else begin
                    w_job = w_raw;
                end
                n_bytes_held = 2'd0;
                n_seq_len    = 3'd0;
                n_accum      = '0;
            end else if (i_end_of_text || r_bytes_held == 2'd3) begin
                w_job        = w_raw;
                n_bytes_held = 2'd0;
                n_seq_len    = 3'd0;
                n_accum      = '0;
            end else begin
                unique case (r_bytes_held)
                    2'd0:    n_held0 = i_data_byte;
                    2'd1:    n_held1 = i_data_byte;
                    default: n_held2 = i_data_byte;
                endcase
                n_bytes_held = r_bytes_held + 2'd1;
                n_accum      = w_cp;
            end
        end
        if (i_end_of_text) begin
            n_bytes_held = 2'd0;
            n_seq_len    = 3'd0;
            n_accum      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_held <= 2'd0;
            r_seq_len    <= 3'd0;
            r_accum      <= '0;
        end else if (i_accept) begin
            r_bytes_held <= n_bytes_held;
            r_seq_len    <= n_seq_len;
            r_accum      <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_held2 <= n_held2;
        end
    end

    assign o_push = i_accept && (w_job.count != 3'd0);
    assign o_job  = w_job;
    assign o_idle = (r_seq_len == 3'd0);

endmodule

// ===== design/u8s_queue.sv =====
// ---------------------------------------------------------------------------
// u8s_queue
// small job fifo between front and back end
// ---------------------------------------------------------------------------
module u8s_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8s_pkg::t_job        i_job,
    input  logic                 i_pop,
    output u8s_pkg::t_job        o_job,
    output u8s_pkg::t_q_status   o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8s_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW-1:0] n_wr_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? f_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? f_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== design/u8s_back.sv =====
// ---------------------------------------------------------------------------
// u8s_back
// job serializer, one output byte per transaction
// ---------------------------------------------------------------------------
module u8s_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8s_pkg::t_job        i_job,
    input  u8s_pkg::t_q_status   i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_last
);

    logic          r_busy, n_busy;
    logic [1:0]    r_idx, n_idx;
    u8s_pkg::t_job r_job;
    logic          w_take;
    logic          w_last;

    assign w_take = r_busy && !i_out_stall;
    assign w_last = ({1'b0, r_idx} == (r_job.count - 3'd1));
    assign o_pop  = !i_q_status.empty && (!r_busy || (w_take && w_last));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (w_take) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    assign o_out_valid = r_busy;
    assign o_out_byte  = r_job.bytes[r_idx];
    assign o_run_last  = w_last;

endmodule

// ===== design/utf8_text_sanitizer_core.sv =====
// ---------------------------------------------------------------------------
// utf8_text_sanitizer_core
// output path: a completing byte's job is written into the queue, then loaded into the back end job register
// throughput: 1 input byte per cycle unless the queue is full; output 1 byte per cycle while not stalled,
// a job's bytes go out one at a time, and the job queue absorbs bursts of multi-byte jobs
// reset: synchronous active-low, clears decoder state, queue pointers, output valid
// ---------------------------------------------------------------------------
`include "utf8_text_sanitizer_core_assert.svh"

module utf8_text_sanitizer_core #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_text,
    // output byte channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    // front end: assembles multi-byte sequences and turns each accepted
    // byte into a job of zero to four output bytes
    // queue: holds jobs so the front keeps taking bytes while the back
    // end drains a long flush
    // back end: walks through one job, one byte per output transaction

    logic                 w_in_accept;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_front_idle;
    u8s_pkg::t_job        w_front_job;
    u8s_pkg::t_job        w_head_job;
    u8s_pkg::t_q_status   w_q_status;

    // stall only when there is no room for another job
    assign o_in_stall  = w_q_status.full;
    assign w_in_accept = i_in_valid && !o_in_stall;

    u8s_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (w_push),
        .o_job         (w_front_job),
        .o_idle        (w_front_idle)
    );

    u8s_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    u8s_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

    // a job is never written into a full queue
    `U8S_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full)
    // an idle back end picks up a waiting job at once
    `U8S_ASSERT_NXT(a_back_loads, i_clk, i_rst_n, !o_out_valid && !w_q_status.empty, o_out_valid)
    // end of text always leaves the decoder idle
    `U8S_ASSERT_NXT(a_eot_idle, i_clk, i_rst_n, w_in_accept && i_end_of_text, w_front_idle)

endmodule
